// File: sv/multilevel_priority_queue_unit_macros.svh
// Assertion macros for the multilevel priority queue unit.
// Included by the checker; no other dependencies.
`ifndef MULTILEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MULTILEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside the disable condition.
`define MPQ_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define MPQ_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/mpq_pkg.sv
// Shared types and constants for the multilevel priority queue unit.
// No dependencies.
package mpq_pkg;

    localparam int MPQ_MAX_LEVELS = 8;
    localparam int MPQ_MAX_DEPTH  = 16;

    localparam int LEVELS_W   = 4;
    localparam int CAP_W      = 5;
    localparam int PRIO_W     = 4;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int CNT_W      = 7;

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 4'd8;
    localparam logic [CAP_W-1:0]    CAP_RESET    = 5'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_LEVELS   = 1'b0,
        REG_CAPACITY = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        status_t             status;
        logic [PRIO_W-1:0]   prio;
        logic                del_ok;
    } mpq_result_t;

endpackage

// File: sv/mpq_store.sv
// Entry store of the priority queue: one row of slots per level.
// Single address port, registered read data. Depends on nothing.
module mpq_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mpq_ctrl.sv
// Level index table and request decode of the priority queue.
// Holds per-level head and tail indices; depends on mpq_pkg.
module mpq_ctrl
    import mpq_pkg::*;
#(
    parameter int MAX_LEVELS = MPQ_MAX_LEVELS,
    parameter int MAX_DEPTH  = MPQ_MAX_DEPTH,
    parameter int AW         = $clog2(MAX_LEVELS * MAX_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  cmd_t                cmd,
    input  logic [PRIO_W-1:0]   prio,
    input  logic [LEVELS_W-1:0] levels,
    input  logic [CAP_W-1:0]    capacity,
    output logic                mem_we,
    output logic                mem_re,
    output logic [AW-1:0]       mem_addr,
    output mpq_result_t         result
);

    localparam int LW = $clog2(MAX_LEVELS);
    localparam int HW = $clog2(MAX_DEPTH);
    localparam int TW = $clog2(MAX_DEPTH + 1);

    logic [HW-1:0]    head_reg  [MAX_LEVELS];
    logic [HW-1:0]    head_next [MAX_LEVELS];
    logic [TW-1:0]    tail_reg  [MAX_LEVELS];
    logic [TW-1:0]    tail_next [MAX_LEVELS];

    logic [CNT_W-1:0] lev_eff;
    logic [CNT_W-1:0] cap_eff;
    logic             found;
    logic [LW-1:0]    sel_row;
    logic [LW-1:0]    ins_row;
    logic [LW-1:0]    idx;
    logic [HW-1:0]    cur_head;
    logic [TW-1:0]    cur_tail;
    logic [HW-1:0]    slot;
    logic [CNT_W-1:0] sel_level;
    logic             ins_range;
    logic             ins_full;

    always_comb begin
        lev_eff = ({3'b000, levels} > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS)
                                                          : {3'b000, levels};
        cap_eff = ({2'b00, capacity} > CNT_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH)
                                                          : {2'b00, capacity};

        found   = 1'b0;
        sel_row = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (tail_reg[i] != '0 && CNT_W'(i) < lev_eff) begin
                found   = 1'b1;
                sel_row = LW'(i);
            end
        end

        ins_row   = LW'(prio - 4'd1);
        ins_range = (prio == '0) || ({3'b000, prio} > lev_eff);
        idx       = (cmd == CMD_DELETE) ? sel_row : ins_row;
        cur_head  = head_reg[idx];
        cur_tail  = tail_reg[idx];
        ins_full  = CNT_W'(cur_tail) >= cap_eff;
        slot      = (cmd == CMD_DELETE) ? cur_head : HW'(cur_tail);
        sel_level = CNT_W'(sel_row) + CNT_W'(1);
        mem_addr  = AW'(AW'(idx) * AW'(MAX_DEPTH) + AW'(slot));

        head_next = head_reg;
        tail_next = tail_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        result    = '{status: ST_OK, prio: '0, del_ok: 1'b0};

        unique case (cmd)
            CMD_INSERT: begin
                if (ins_range) begin
                    result.status = ST_RANGE;
                end else if (ins_full) begin
                    result.status = ST_FULL;
                end else begin
                    mem_we         = fire;
                    tail_next[idx] = cur_tail + TW'(1);
                end
            end
            CMD_DELETE: begin
                if (!found) begin
                    result.status = ST_EMPTY;
                end else begin
                    mem_re        = fire;
                    result.prio   = sel_level[PRIO_W-1:0];
                    result.del_ok = 1'b1;
                    if (CNT_W'(cur_head) + CNT_W'(1) >= CNT_W'(cur_tail)) begin
                        head_next[idx] = '0;
                        tail_next[idx] = '0;
                    end else begin
                        head_next[idx] = cur_head + HW'(1);
                    end
                end
            end
            default: begin
                result.status = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else if (fire) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule

// File: sv/multilevel_priority_queue_unit.sv
// A priority queue built from one FIFO per priority level. Each request (insert or delete) is
// registered on entry in the input register, decoded there against the level index table, and
// its result is registered at the edge that moves it on, so m_tvalid rises once the request
// has passed the input and result registers. While results are taken, one request is accepted
// every cycle; a stalled result holds both stages and drops s_tready once the input register is
// also full. The delete value comes from the registered read port of the entry store, which is
// read at the edge that registers the result. The entry store needs no clearing after reset;
// only slots below a level's tail are ever read.
// Depends on mpq_pkg, mpq_ctrl and mpq_store.
module multilevel_priority_queue_unit
    import mpq_pkg::*;
#(
    parameter int MAX_LEVELS = MPQ_MAX_LEVELS,
    parameter int MAX_DEPTH  = MPQ_MAX_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // priority_req[3:0], value[35:4], zero fill
    input  logic                  s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // status[1:0], out_value[33:2], out_priority[37:34]
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH = MAX_LEVELS * MAX_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [LEVELS_W-1:0] levels_reg;
    logic [CAP_W-1:0]    cap_reg;

    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic [PRIO_W-1:0]   in_prio_reg;
    logic [VALUE_W-1:0]  in_value_reg;

    logic                res_valid_reg;
    mpq_result_t         res_reg;

    logic                advance;
    logic                fire;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;
    logic [VALUE_W-1:0]  mem_rdata;
    mpq_result_t         result;
    logic [VALUE_W-1:0]  out_value;

    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            levels_reg    <= LEVELS_RESET;
            cap_reg       <= CAP_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                res_valid_reg <= in_valid_reg;
            end
            if (cfg_we) begin
                if (cfg_index == REG_LEVELS) begin
                    levels_reg <= cfg_wdata[LEVELS_W-1:0];
                end else begin
                    cap_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_prio_reg  <= s_tdata[PRIO_W-1:0];
            in_value_reg <= s_tdata[PRIO_W+VALUE_W-1:PRIO_W];
        end
        if (fire) begin
            res_reg <= result;
        end
    end

    mpq_ctrl #(
        .MAX_LEVELS (MAX_LEVELS),
        .MAX_DEPTH  (MAX_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .cmd      (in_cmd_reg),
        .prio     (in_prio_reg),
        .levels   (levels_reg),
        .capacity (cap_reg),
        .mem_we   (mem_we),
        .mem_re   (mem_re),
        .mem_addr (mem_addr),
        .result   (result)
    );

    mpq_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (in_value_reg),
        .rdata (mem_rdata)
    );

    assign out_value = res_reg.del_ok ? mem_rdata : '0;
    assign m_tvalid  = res_valid_reg;
    assign m_tdata   = {2'b00, res_reg.prio, out_value, res_reg.status};

endmodule

// File: sv/mpq_checker.sv
// Port-level checks for the multilevel priority queue unit, bound to the top level.
// Depends on mpq_pkg and multilevel_priority_queue_unit_macros.svh.
`include "multilevel_priority_queue_unit_macros.svh"

module mpq_checker
    import mpq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `MPQ_ASSERT_NEXT(a_hold_stalled, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MPQ_ASSERT_SAME(a_fail_zero, aclk, !aresetn, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[37:2] == '0)
    `MPQ_ASSERT_SAME(a_no_bubble, aclk, !aresetn, m_tready, s_tready)
    `MPQ_ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_tvalid && s_tready)

endmodule

bind multilevel_priority_queue_unit mpq_checker u_mpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/multilevel_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for multilevel_priority_queue_unit: a directed table, then random
// phases with new level and capacity settings. Results are checked against the table where
// it gives them, else against an in-bench queue model. Depends on mpq_pkg and the unit.
module multilevel_priority_queue_unit_tb;
    import mpq_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
    } queue_result_t;

    typedef enum bit {
        ROW_OP  = 1'b0,
        ROW_CFG = 1'b1
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t              kind;
        cfg_reg_t                sel;
        logic [CFG_DATA_W-1:0]   wdata;
        cmd_t                    cmd;
        logic [PRIO_W-1:0]       prio;
        logic [VALUE_W-1:0]      value;
        bit                      known;
        status_t                 st;
        logic [VALUE_W-1:0]      rvalue;
        logic [PRIO_W-1:0]       rprio;
    } plan_row_t;

    localparam int PLAN_LEN     = 33;
    localparam int RANDOM_ITEMS = 950;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    multilevel_priority_queue_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // kind, register, wdata, cmd, priority, value, known, status, out value, out priority
    plan_row_t directed_plan [PLAN_LEN] = '{
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b1, ST_EMPTY, 32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd0,  32'h0000_0001,
          1'b1, ST_RANGE, 32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd9,  32'h0000_0001,
          1'b1, ST_RANGE, 32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd15, 32'hFFFF_FFFF,
          1'b1, ST_RANGE, 32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd1,  32'h8000_0000,
          1'b1, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd8,  32'h7FFF_FFFF,
          1'b1, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd8,  32'hA5A5_A5A5,
          1'b1, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b1, ST_OK,    32'h7FFF_FFFF, 4'd8},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b1, ST_OK,    32'hA5A5_A5A5, 4'd8},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b1, ST_OK,    32'h8000_0000, 4'd1},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd15, 32'hFFFF_FFFF,
          1'b1, ST_EMPTY, 32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_LEVELS,   5'h11, CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd2,  32'h0000_0002,
          1'b1, ST_RANGE, 32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd1,  32'h1234_5678,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_CAPACITY, 5'd1,  CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd1,  32'h0000_0000,
          1'b1, ST_FULL,  32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b1, ST_OK,    32'h1234_5678, 4'd1},
        '{ROW_CFG, REG_LEVELS,   5'd0,  CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd1,  32'h0000_0003,
          1'b1, ST_RANGE, 32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b1, ST_EMPTY, 32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_CAPACITY, 5'd0,  CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_LEVELS,   5'd15, CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd8,  32'h0000_0004,
          1'b1, ST_FULL,  32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd9,  32'h0000_0005,
          1'b1, ST_RANGE, 32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_CAPACITY, 5'd31, CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd8,  32'h55AA_55AA,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_INSERT, 4'd3,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_LEVELS,   5'd4,  CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_LEVELS,   5'd8,  CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_OP,  REG_LEVELS,   5'd0,  CMD_DELETE, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0},
        '{ROW_CFG, REG_CAPACITY, 5'd16, CMD_INSERT, 4'd0,  32'h0000_0000,
          1'b0, ST_OK,    32'h0000_0000, 4'd0}
    };

    logic [LEVELS_W-1:0] cur_levels;
    logic [CAP_W-1:0]    cur_capacity;
    int                  lvl_head [MPQ_MAX_LEVELS];
    int                  lvl_tail [MPQ_MAX_LEVELS];
    logic [VALUE_W-1:0]  lvl_slots [MPQ_MAX_LEVELS][MPQ_MAX_DEPTH];

    queue_result_t awaited_results[$];
    int            mismatch_count = 0;
    int            burst_left = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int levels_active();
        return (cur_levels > MPQ_MAX_LEVELS) ? MPQ_MAX_LEVELS : int'(cur_levels);
    endfunction

    function automatic queue_result_t predict_queue_op(input cmd_t c, input logic [PRIO_W-1:0] p,
                                                       input logic [VALUE_W-1:0] v);
        queue_result_t r;
        int            lim;
        int            cap;
        int            row;
        bit            served;
        r.status = ST_OK;
        r.value  = '0;
        r.prio   = '0;
        lim = levels_active();
        cap = (cur_capacity > MPQ_MAX_DEPTH) ? MPQ_MAX_DEPTH : int'(cur_capacity);
        if (c == CMD_INSERT) begin
            if (p == 0 || p > lim) begin
                r.status = ST_RANGE;
            end else begin
                row = p - 1;
                if (lvl_tail[row] >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    lvl_slots[row][lvl_tail[row]] = v;
                    lvl_tail[row]++;
                end
            end
        end else begin
            r.status = ST_EMPTY;
            served = 1'b0;
            for (int q = lim; q >= 1; q--) begin
                row = q - 1;
                if (!served && lvl_tail[row] != 0) begin
                    served   = 1'b1;
                    r.status = ST_OK;
                    r.value  = lvl_slots[row][lvl_head[row]];
                    r.prio   = q[PRIO_W-1:0];
                    if (lvl_head[row] + 1 >= lvl_tail[row]) begin
                        lvl_head[row] = 0;
                        lvl_tail[row] = 0;
                    end else begin
                        lvl_head[row]++;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
        if (mismatch_count < 100) begin
            $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    task automatic send_request(input cmd_t c, input logic [PRIO_W-1:0] p,
                                input logic [VALUE_W-1:0] v, input bit from_table,
                                input queue_result_t table_result);
        queue_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {4'b0000, v, p};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_queue_op(c, p, v);
        awaited_results.push_back(from_table ? table_result : predicted);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_requests();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
        end
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= data;
        @(posedge aclk);
        if (which == REG_LEVELS) begin
            cur_levels = data[LEVELS_W-1:0];
        end else begin
            cur_capacity = data;
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int mode;
        int span;
        m_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 4) != 0);
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 5) == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with no request pending", m_tdata[VALUE_W-1:0], '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[1:0] != want.status) begin
                    flag_mismatch("status", VALUE_W'(m_tdata[1:0]), VALUE_W'(want.status));
                end
                if (m_tdata[33:2] != want.value) begin
                    flag_mismatch("out_value", m_tdata[33:2], want.value);
                end
                if (m_tdata[37:34] != want.prio) begin
                    flag_mismatch("out_priority", VALUE_W'(m_tdata[37:34]),
                                  VALUE_W'(want.prio));
                end
            end
        end
    end

    initial begin
        queue_result_t       tr;
        int                  sent_random;
        int                  phase_len;
        int                  ins_pct;
        int                  lim;
        int                  pick;
        cmd_t                c;
        logic [PRIO_W-1:0]   p;
        logic [LEVELS_W-1:0] lv;
        logic [CAP_W-1:0]    cp;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_LEVELS;
        cfg_wdata <= '0;
        cur_levels   = LEVELS_RESET;
        cur_capacity = CAP_RESET;
        for (int i = 0; i < MPQ_MAX_LEVELS; i++) begin
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                drain_requests();
                write_reg(directed_plan[i].sel, directed_plan[i].wdata);
            end else begin
                tr.status = directed_plan[i].st;
                tr.value  = directed_plan[i].rvalue;
                tr.prio   = directed_plan[i].rprio;
                send_request(directed_plan[i].cmd, directed_plan[i].prio,
                             directed_plan[i].value, directed_plan[i].known, tr);
                pace_sender();
            end
        end

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            drain_requests();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                lv = 4'd0;
            end else if (pick == 1) begin
                lv = LEVELS_W'($urandom_range(9, 15));
            end else begin
                lv = LEVELS_W'($urandom_range(1, 8));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                cp = 5'd0;
            end else if (pick == 1) begin
                cp = CAP_W'($urandom_range(17, 31));
            end else if (pick == 2) begin
                cp = 5'd16;
            end else begin
                cp = CAP_W'($urandom_range(1, 6));
            end
            write_reg(REG_LEVELS, {1'($urandom_range(0, 1)), lv});
            write_reg(REG_CAPACITY, cp);
            lim       = levels_active();
            phase_len = (lim == 0) ? $urandom_range(5, 15) : $urandom_range(30, 120);
            if (phase_len > RANDOM_ITEMS - sent_random) begin
                phase_len = RANDOM_ITEMS - sent_random;
            end
            case ($urandom_range(0, 3))
                0: ins_pct = 35;
                1: ins_pct = 50;
                2: ins_pct = 70;
                default: ins_pct = 85;
            endcase
            repeat (phase_len) begin
                c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
                if (lim == 0 || $urandom_range(0, 9) == 0) begin
                    p = PRIO_W'($urandom_range(0, 15));
                end else begin
                    p = PRIO_W'($urandom_range(1, lim));
                end
                send_request(c, p, $urandom(), 1'b0, tr);
                pace_sender();
                sent_random++;
            end
        end

        drain_requests();
        repeat (8) @(posedge aclk);
        while (awaited_results.size() != 0) begin
            tr = awaited_results.pop_front();
            flag_mismatch("result never delivered", '0, tr.value);
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
